// ===== rtl/core/shss_pkg.sv =====
// ----------------------------------------------------------------------------
// shss_pkg: stepper half-step sequencer package
// Shared widths, state encodings, register indexes and the coil table.
// ----------------------------------------------------------------------------
package shss_pkg;

	// Longest step period in ticks; the period register is sized from it.
	localparam int unsigned MAX_PERIOD = 255;
	localparam int unsigned PERIOD_W   = $clog2(MAX_PERIOD + 1);

	localparam int unsigned CODE_W        = 32;
	localparam int unsigned COIL_W        = 4;
	localparam int unsigned STEP_PERIOD_W = 8;
	localparam int unsigned PHASE_W       = 3;
	localparam int unsigned CFG_INDEX_W   = 2;

	// Remote codes loaded at reset.
	localparam logic [CODE_W-1:0] RST_CODE_RIGHT = 32'h00FF_C23D;
	localparam logic [CODE_W-1:0] RST_CODE_LEFT  = 32'h00FF_22DD;
	localparam logic [CODE_W-1:0] RST_CODE_UP    = 32'h00FF_906F;
	localparam logic [CODE_W-1:0] RST_CODE_DOWN  = 32'h00FF_E01F;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_CODE_RIGHT = 2'd0,
		CFG_CODE_LEFT  = 2'd1,
		CFG_CODE_UP    = 2'd2,
		CFG_CODE_DOWN  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		SPD_INIT = 2'd0,
		SPD_WAIT = 2'd1,
		SPD_UP   = 2'd2,
		SPD_DOWN = 2'd3
	} speed_state_t;

	typedef enum logic [1:0] {
		ROT_INIT = 2'd0,
		ROT_L    = 2'd1,
		ROT_R    = 2'd2
	} rot_state_t;

	// Half-step coil pattern, IN1 in the top bit.
	function automatic logic [COIL_W-1:0] coil_of(input logic [PHASE_W-1:0] phase);
		logic [COIL_W-1:0] pat;
		unique case (phase)
			3'd0: pat = 4'h1;
			3'd1: pat = 4'h3;
			3'd2: pat = 4'h2;
			3'd3: pat = 4'h6;
			3'd4: pat = 4'h4;
			3'd5: pat = 4'hC;
			3'd6: pat = 4'h8;
			3'd7: pat = 4'h9;
			default: pat = 4'h1;
		endcase
		return pat;
	endfunction

endpackage

// ===== rtl/core/shss_in_if.sv =====
// ----------------------------------------------------------------------------
// shss_in_if: tick input channel
// Valid/ready channel carrying the last received remote code per tick.
// ----------------------------------------------------------------------------
interface shss_in_if
	import shss_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] ir_code;

	modport source (output valid, output ir_code, input ready);
	modport sink   (input valid, input ir_code, output ready);
endinterface

// ===== rtl/core/shss_out_if.sv =====
// ----------------------------------------------------------------------------
// shss_out_if: result channel
// Valid/ready channel carrying coil pattern, direction and step period.
// ----------------------------------------------------------------------------
interface shss_out_if
	import shss_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [COIL_W-1:0]        coil_pattern;
	logic                     direction;
	logic [STEP_PERIOD_W-1:0] step_period;

	modport source (output valid, output coil_pattern, output direction,
		output step_period, input ready);
	modport sink   (input valid, input coil_pattern, input direction,
		input step_period, output ready);
endinterface

// ===== rtl/core/stepper_half_step_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// stepper_half_step_sequencer_core: half-step stepper sequencer
// Turns per-tick remote codes into coil drive patterns, direction and speed.
// ----------------------------------------------------------------------------
// Each input beat is one tick carrying the most recently received remote
// code, and each tick produces exactly one output beat with the coil pattern
// of the current half-step phase, the rotation direction and the current step
// period. The block takes one beat per clock as long as the sink keeps taking
// results: all state (speed and rotation controllers, period, tick counter,
// phase) is updated in the same cycle the beat is accepted, and the result
// lands in a single output register, valid from the next cycle. The input is
// ready whenever the output register is empty or is being emptied in that
// cycle. The four remote codes (right, left, up, down) are configuration
// registers written through the plain write port; the user must write them
// only while the block is idle, and the block does not enforce this. They
// reset to the usual codes of a common handheld remote. Up and down presses
// change the period by one tick once per press and re-arm only after a code
// that is neither. Right steps the phase up from 0, left steps it down from 7.
// ----------------------------------------------------------------------------
module stepper_half_step_sequencer_core
	import shss_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CODE_W-1:0]      cfg_wdata,
	shss_in_if.sink                in_ch,
	shss_out_if.source             out_ch
);

	// Configuration registers.
	logic [CODE_W-1:0] code_right_q, code_left_q, code_up_q, code_down_q;

	// Controller state.
	speed_state_t        speed_q, speed_n;
	rot_state_t          rot_q, rot_n;
	logic [PERIOD_W-1:0] period_q, period_n;
	logic [PERIOD_W-1:0] tick_q, tick_n;
	logic [PHASE_W-1:0]  phase_q, phase_n;

	// Result register.
	logic                     out_valid_q;
	logic [COIL_W-1:0]        coil_q, coil_n;
	logic                     dir_q, dir_n;
	logic [STEP_PERIOD_W-1:0] step_period_q, step_period_n;

	logic              accept;
	logic              is_up, is_down, is_right, is_left;
	logic [PERIOD_W:0] tick_inc;
	logic              step_fire;

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign is_up    = (in_ch.ir_code == code_up_q);
	assign is_down  = (in_ch.ir_code == code_down_q);
	assign is_right = (in_ch.ir_code == code_right_q);
	assign is_left  = (in_ch.ir_code == code_left_q);

	// Configuration writes; the write is taken whenever the enable is high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_right_q <= RST_CODE_RIGHT;
			code_left_q  <= RST_CODE_LEFT;
			code_up_q    <= RST_CODE_UP;
			code_down_q  <= RST_CODE_DOWN;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_CODE_RIGHT: code_right_q <= cfg_wdata;
				CFG_CODE_LEFT:  code_left_q  <= cfg_wdata;
				CFG_CODE_UP:    code_up_q    <= cfg_wdata;
				CFG_CODE_DOWN:  code_down_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Speed controller: one period change per press, saturating at both ends.
	// The first tick after reset only arms the controller.
	always_comb begin
		speed_n  = speed_q;
		period_n = period_q;
		unique case (speed_q)
			SPD_WAIT: begin
				if (is_up) begin
					if (period_q > PERIOD_W'(1)) period_n = period_q - PERIOD_W'(1);
					speed_n = SPD_UP;
				end else if (is_down) begin
					if (period_q < PERIOD_W'(MAX_PERIOD)) period_n = period_q + PERIOD_W'(1);
					speed_n = SPD_DOWN;
				end
			end
			SPD_UP, SPD_DOWN: begin
				if (!is_up && !is_down) speed_n = SPD_WAIT;
			end
			default: speed_n = SPD_WAIT;
		endcase
	end

	// The tick counter runs against the already-updated period, so a period
	// that shrinks below the count makes the step fire on this tick.
	assign tick_inc  = {1'b0, tick_q} + {{PERIOD_W{1'b0}}, 1'b1};
	assign step_fire = (tick_inc >= {1'b0, period_n});

	// Rotation controller. A direction code restarts the sequence at its
	// end phase and overrides any step taken on the same tick.
	always_comb begin
		rot_n   = rot_q;
		tick_n  = tick_q;
		phase_n = phase_q;
		unique case (rot_q)
			ROT_L: begin
				if (step_fire) begin
					tick_n  = '0;
					phase_n = phase_q - PHASE_W'(1);
				end else begin
					tick_n = tick_inc[PERIOD_W-1:0];
				end
				if (is_right) begin
					rot_n   = ROT_R;
					phase_n = '0;
					tick_n  = '0;
				end
			end
			ROT_R: begin
				if (step_fire) begin
					tick_n  = '0;
					phase_n = phase_q + PHASE_W'(1);
				end else begin
					tick_n = tick_inc[PERIOD_W-1:0];
				end
				if (is_left) begin
					rot_n   = ROT_L;
					phase_n = '1;
					tick_n  = '0;
				end
			end
			default: begin
				rot_n  = ROT_L;
				tick_n = '0;
			end
		endcase
	end

	// Result of the tick, taken from the updated state.
	always_comb begin
		coil_n        = coil_of(phase_n);
		dir_n         = (rot_n == ROT_R);
		step_period_n = STEP_PERIOD_W'(period_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q  <= SPD_INIT;
			rot_q    <= ROT_INIT;
			period_q <= PERIOD_W'(1);
			tick_q   <= '0;
			phase_q  <= '0;
		end else if (accept) begin
			speed_q  <= speed_n;
			rot_q    <= rot_n;
			period_q <= period_n;
			tick_q   <= tick_n;
			phase_q  <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			coil_q        <= coil_n;
			dir_q         <= dir_n;
			step_period_q <= step_period_n;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.coil_pattern = coil_q;
	assign out_ch.direction    = dir_q;
	assign out_ch.step_period  = step_period_q;

endmodule

// ===== sim/tb_stepper_half_step_sequencer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stepper_half_step_sequencer_core: self-checking bench for the sequencer
// Drives tick beats carrying remote codes, predicts coil pattern, direction
// and step period for every tick, and checks each result beat in order.
// ----------------------------------------------------------------------------
module tb_stepper_half_step_sequencer_core;
	import shss_pkg::*;

	localparam int unsigned HALF_PERIOD  = 5;
	localparam int unsigned RESET_CYCLES = 4;
	// The block registers its result once, so the settle wait covers any stray beat.
	localparam int unsigned SETTLE_CYCLES = 4;
	// Roughly 1200 ticks in total, with a wide margin.
	localparam int unsigned CYCLE_LIMIT = 400000;

	// Half-step coil sequence, four bits per phase, phase 0 in the low nibble.
	localparam logic [8*COIL_W-1:0] HALF_STEP_COILS = 32'h98C4_6231;

	typedef struct packed {
		logic [COIL_W-1:0]        coil;
		logic                     dir;
		logic [STEP_PERIOD_W-1:0] period;
	} step_result_t;

	// Receiver behavior, switched at random.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_RANDOM,
		RX_EVERY_THIRD,
		RX_LONG_STALLS
	} rx_pattern_t;

	logic clk;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CODE_W-1:0]      cfg_wdata;

	shss_in_if  in_ch();
	shss_out_if out_ch();

	stepper_half_step_sequencer_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// ------------------------------------------------------------------------
	// Predictor state. The bench resets the block once, so the shadow copy
	// starts at the reset values and is never reloaded.
	// ------------------------------------------------------------------------
	logic [CODE_W-1:0]   code_right_q = RST_CODE_RIGHT;
	logic [CODE_W-1:0]   code_left_q  = RST_CODE_LEFT;
	logic [CODE_W-1:0]   code_up_q    = RST_CODE_UP;
	logic [CODE_W-1:0]   code_down_q  = RST_CODE_DOWN;
	speed_state_t        speed_q      = SPD_INIT;
	rot_state_t          rot_q        = ROT_INIT;
	logic [PERIOD_W-1:0] period_q     = 1;
	int unsigned         ticks_q      = 0;
	logic [PHASE_W-1:0]  phase_q      = '0;

	// Ticks waiting to go out, and results waiting to come back.
	logic [CODE_W-1:0] tick_q[$];
	step_result_t      expected_q[$];

	int unsigned err_count     = 0;
	int unsigned results_seen  = 0;
	int unsigned ticks_sent    = 0;
	int unsigned settings_used = 1;
	int unsigned period_floor  = MAX_PERIOD;
	int unsigned period_peak   = 0;
	int unsigned cycle_count   = 0;

	int unsigned  burst_left = 0;
	int unsigned  gap_left   = 0;
	step_result_t next_result;
	step_result_t want_result;

	rx_pattern_t  rx_mode    = RX_ALWAYS;
	int unsigned  rx_left    = 0;
	int unsigned  stall_left = 0;
	logic         take_now;

	initial clk = 1'b0;
	always #(HALF_PERIOD) clk = ~clk;

	// One tick of the sequencer: the speed controller acts on the code first,
	// then the rotation controller counts, steps and reacts to turn codes.
	task automatic advance_tick(input logic [CODE_W-1:0] code, output step_result_t res);
		logic hit_up;
		logic hit_down;
		hit_up   = (code == code_up_q);
		hit_down = (code == code_down_q);

		// A press changes the period once; it re-arms only on a code that is
		// neither up nor down. Up wins when a code matches both.
		case (speed_q)
			SPD_WAIT: begin
				if (hit_up) begin
					if (period_q > 1) period_q = period_q - 1'b1;
					speed_q = SPD_UP;
				end else if (hit_down) begin
					if (period_q < MAX_PERIOD) period_q = period_q + 1'b1;
					speed_q = SPD_DOWN;
				end
			end
			SPD_UP, SPD_DOWN: begin
				if (!hit_up && !hit_down) speed_q = SPD_WAIT;
			end
			default: speed_q = SPD_WAIT;
		endcase

		// The step fires once the count reaches the period, which also covers
		// a period that was just shortened below the running count. Right is
		// only looked at while turning L, and left only while turning r.
		case (rot_q)
			ROT_L: begin
				ticks_q++;
				if (ticks_q >= period_q) begin
					ticks_q = 0;
					phase_q = phase_q - 1'b1;
				end
				if (code == code_right_q) begin
					rot_q   = ROT_R;
					phase_q = '0;
					ticks_q = 0;
				end
			end
			ROT_R: begin
				ticks_q++;
				if (ticks_q >= period_q) begin
					ticks_q = 0;
					phase_q = phase_q + 1'b1;
				end
				if (code == code_left_q) begin
					rot_q   = ROT_L;
					phase_q = '1;
					ticks_q = 0;
				end
			end
			default: begin
				rot_q   = ROT_L;
				ticks_q = 0;
			end
		endcase

		if (period_q < period_floor) period_floor = period_q;
		if (period_q > period_peak) period_peak = period_q;

		res.coil   = HALF_STEP_COILS[phase_q*COIL_W +: COIL_W];
		res.dir    = (rot_q == ROT_R);
		res.period = period_q[STEP_PERIOD_W-1:0];
	endtask

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned want);
		$display("%0t: mismatch on %s, got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	// Writes one code register through the plain write port and mirrors it in
	// the predictor. Only called while no tick is in flight.
	task automatic write_code(input cfg_index_t idx, input logic [CODE_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_CODE_RIGHT: code_right_q = value;
			CFG_CODE_LEFT:  code_left_q  = value;
			CFG_CODE_UP:    code_up_q    = value;
			CFG_CODE_DOWN:  code_down_q  = value;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Blocks until every queued tick has been taken and every result beat has
	// come back, then lets the pipeline settle. Checked on the falling edge so
	// that all clocked processes of the rising edge are done.
	task automatic wait_drained();
		@(negedge clk);
		while (tick_q.size() != 0 || in_ch.valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Queues remote traffic shaped like real use: presses held for a few
	// ticks and then released, turn codes held for a while, and some noise
	// (random codes and codes one bit away from a register). broken_pct of
	// the presses are not released, so the next press lands on a held state.
	task automatic queue_remote_traffic(input int unsigned n_items, input int unsigned w_up,
		input int unsigned w_down, input int unsigned w_turn, input int unsigned hold_max,
		input int unsigned broken_pct);
		int unsigned       added;
		int unsigned       pick;
		int unsigned       hold;
		logic [CODE_W-1:0] code;
		added = 0;
		while (added < n_items) begin
			pick = $urandom_range(99);
			if (pick < w_up + w_down) begin
				code = (pick < w_up) ? code_up_q : code_down_q;
				hold = $urandom_range(1, hold_max);
				repeat (hold) tick_q.push_back(code);
				added += hold;
				if ($urandom_range(99) >= broken_pct) begin
					code = $urandom;
					hold = $urandom_range(1, hold_max);
					repeat (hold) tick_q.push_back(code);
					added += hold;
				end
			end else if (pick < w_up + w_down + w_turn) begin
				code = $urandom_range(1) ? code_right_q : code_left_q;
				hold = $urandom_range(1, hold_max + 2);
				repeat (hold) tick_q.push_back(code);
				added += hold;
			end else begin
				case ($urandom_range(4))
					0: code = code_right_q;
					1: code = code_left_q;
					2: code = code_up_q;
					3: code = code_down_q;
					default: code = $urandom;
				endcase
				if (pick[0]) code = code ^ (32'h1 << $urandom_range(CODE_W - 1));
				tick_q.push_back(code);
				added++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Tick driver. A beat is taken at a rising edge with valid and ready both
	// high; the expected result is worked out at that same edge. Beats go out
	// in bursts of random length separated by random gaps, with the odd long
	// burst and the odd zero gap so that back-to-back stretches occur too.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				advance_tick(in_ch.ir_code, next_result);
				expected_q.push_back(next_result);
				ticks_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_ch.valid <= 1'b0;
				end else if (tick_q.size() != 0) begin
					in_ch.valid   <= 1'b1;
					in_ch.ir_code <= tick_q.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = ($urandom_range(7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
						gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver. Ready follows a pattern that is switched at random: always
	// ready, random stalls, ready one cycle in three, or long stalls now and then.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_pattern_t'($urandom_range(3));
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_ALWAYS:      take_now = 1'b1;
			RX_RANDOM:      take_now = ($urandom_range(9) >= 3);
			RX_EVERY_THIRD: take_now = (rx_left % 3 == 0);
			default: begin
				if (stall_left != 0) begin
					stall_left--;
					take_now = 1'b0;
				end else begin
					take_now = 1'b1;
					if ($urandom_range(7) == 0) stall_left = $urandom_range(5, 15);
				end
			end
		endcase
		out_ch.ready <= take_now;
	end

	// ------------------------------------------------------------------------
	// Result monitor. Every accepted result beat is matched against the
	// oldest expectation, field by field.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch("result beat with no tick outstanding", out_ch.coil_pattern, 0);
			end else begin
				want_result = expected_q.pop_front();
				if (out_ch.coil_pattern !== want_result.coil)
					report_mismatch("coil_pattern", out_ch.coil_pattern, want_result.coil);
				if (out_ch.direction !== want_result.dir)
					report_mismatch("direction", out_ch.direction, want_result.dir);
				if (out_ch.step_period !== want_result.period)
					report_mismatch("step_period", out_ch.step_period, want_result.period);
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d ticks queued, %0d results owed.",
				cycle_count, tick_q.size(), expected_q.size());
			$display("[stepper_half_step_sequencer_core] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus. Each phase queues its ticks and then waits until every result
	// is back before the code registers change; that wait is also where the
	// sender sits idle with nothing outstanding.
	// ------------------------------------------------------------------------
	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_wdata     = '0;
		in_ch.valid   = 1'b0;
		in_ch.ir_code = '0;
		out_ch.ready  = 1'b0;

		// Reset codes. The first tick carries up and must be ignored. Then:
		// up at the shortest period stays at 1, a held up does nothing, a
		// release re-arms, down while down is held does nothing, up while
		// down is held does nothing either, right turns to phase 0, a held
		// right in r is ignored, and left turns back to phase 7.
		tick_q.push_back(RST_CODE_UP);
		tick_q.push_back(RST_CODE_UP);
		tick_q.push_back(RST_CODE_UP);
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(RST_CODE_DOWN);
		tick_q.push_back(RST_CODE_DOWN);
		tick_q.push_back(RST_CODE_UP);
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(RST_CODE_DOWN);
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(RST_CODE_RIGHT);
		tick_q.push_back(RST_CODE_RIGHT);
		tick_q.push_back(RST_CODE_LEFT);
		tick_q.push_back(32'hFFFF_FFFF);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		wait_drained();

		// All-zero and all-one codes, with up, down and right sharing a value:
		// up must win over down, and the same code also turns to r while in L.
		write_code(CFG_CODE_RIGHT, 32'h0000_0000);
		write_code(CFG_CODE_LEFT,  32'hFFFF_FFFF);
		write_code(CFG_CODE_UP,    32'h0000_0000);
		write_code(CFG_CODE_DOWN,  32'h0000_0000);
		settings_used++;
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(32'hFFFF_FFFF);
		tick_q.push_back(32'h0000_0000);
		tick_q.push_back(32'h0000_0001);
		wait_drained();

		// Right and left share a value, so holding it flips direction on
		// every tick, since each one is only looked at in the other state.
		write_code(CFG_CODE_RIGHT, 32'hFFFF_FFFF);
		write_code(CFG_CODE_UP,    32'h5555_5555);
		write_code(CFG_CODE_DOWN,  32'hAAAA_AAAA);
		settings_used++;
		tick_q.push_back(32'hFFFF_FFFF);
		tick_q.push_back(32'hFFFF_FFFF);
		tick_q.push_back(32'hFFFF_FFFF);
		tick_q.push_back(32'hAAAA_AAAA);
		wait_drained();

		// Random codes: a balanced walk at short periods, where the phase
		// steps often and the period keeps hitting its floor.
		write_code(CFG_CODE_RIGHT, $urandom);
		write_code(CFG_CODE_LEFT,  $urandom);
		write_code(CFG_CODE_UP,    $urandom);
		write_code(CFG_CODE_DOWN,  $urandom);
		settings_used++;
		queue_remote_traffic(350, 35, 30, 15, 3, 10);
		wait_drained();

		// Same codes: short down presses, one release each, to climb the
		// period all the way to its ceiling.
		queue_remote_traffic(650, 3, 90, 4, 1, 0);
		wait_drained();

		// Back to the reset codes and mostly up presses on the way down.
		write_code(CFG_CODE_RIGHT, RST_CODE_RIGHT);
		write_code(CFG_CODE_LEFT,  RST_CODE_LEFT);
		write_code(CFG_CODE_UP,    RST_CODE_UP);
		write_code(CFG_CODE_DOWN,  RST_CODE_DOWN);
		settings_used++;
		queue_remote_traffic(150, 85, 5, 5, 2, 5);
		wait_drained();

		$display("Sent %0d tick beats and checked %0d result beats under %0d code settings.",
			ticks_sent, results_seen, settings_used);
		$display("Step period spanned %0d to %0d ticks; %0d mismatches found.",
			period_floor, period_peak, err_count);
		if (err_count == 0) begin
			$display("[stepper_half_step_sequencer_core] OK");
		end else begin
			$display("[stepper_half_step_sequencer_core] ERROR");
		end
		$finish;
	end

endmodule
